// ===== hw/rtl/mm4_pkg.sv =====
package mm4_pkg;

  localparam int DATA_W = 32;
  localparam int DIM = 4;
  localparam int IDX_W = 2;
  localparam int ELEM_W = 4;
  localparam int PROD_W = 2 * DATA_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W = PROD_W + 2;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int IN_TDATA_W = 2 * DIM * DATA_W;
  localparam int OUT_TDATA_W = DIM * DATA_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             issue;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic advance;
  } sts_t;

endpackage

// ===== hw/rtl/mm4_ctrl.sv =====
module mm4_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  mm4_pkg::sts_t sts,
  output mm4_pkg::cmd_t cmd
);
  import mm4_pkg::*;

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_COMP = 1'b1;

  logic              state;
  logic              state_next;
  logic [IDX_W-1:0]  load_cnt;
  logic [ELEM_W-1:0] elem_idx;
  logic              fire;

  assign s_tready  = (state == ST_LOAD);
  assign cmd.load  = s_tvalid && s_tready;
  assign cmd.issue = (state == ST_COMP);
  assign cmd.row   = elem_idx[1:0];
  assign cmd.col   = elem_idx[3:2];
  assign fire      = cmd.issue && sts.advance;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (cmd.load && load_cnt == IDX_W'(DIM - 1)) state_next = ST_COMP;
      end
      ST_COMP: begin
        if (fire && elem_idx == ELEM_W'(DIM * DIM - 1)) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      load_cnt <= '0;
      elem_idx <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) load_cnt <= load_cnt + IDX_W'(1);
      if (fire) elem_idx <= elem_idx + ELEM_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_enter_comp: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && load_cnt == IDX_W'(DIM - 1)) |=> (state == ST_COMP && elem_idx == '0))
    else $error("fourth column did not start the computation");
  a_leave_comp: assert property (@(posedge clk) disable iff (rst)
    (fire && elem_idx == ELEM_W'(DIM * DIM - 1)) |=> (state == ST_LOAD && load_cnt == '0))
    else $error("last element issue did not return to loading");
`endif

endmodule

// ===== hw/rtl/mm4_dp.sv =====
module mm4_dp #(
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mm4_pkg::cmd_t                    cmd,
  output mm4_pkg::sts_t                    sts,
  input  logic [mm4_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mm4_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic [mm4_pkg::IDX_W-1:0]        m_tuser,
  output logic                             m_tlast
);
  import mm4_pkg::*;

  // left_m[k][i] holds column k of the left matrix, rotated so that the row
  // being worked on sits at i = 0. right_m is a ring of columns whose head
  // is the result column being worked on.
  logic signed [DATA_W-1:0] left_m  [DIM][DIM];
  logic signed [DATA_W-1:0] right_m [DIM][DIM];

  logic                     en;
  logic                     fire;

  logic                     v1, v2, v3;
  logic [IDX_W-1:0]         row1, row2, row3;
  logic [IDX_W-1:0]         col1, col2, col3;
  logic signed [PROD_W-1:0] prod [DIM];
  logic signed [PAIR_W-1:0] sum01, sum23;
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  shifted;
  logic [DATA_W-1:0]        sat;

  logic [DATA_W-1:0]        coll [DIM-1];
  logic [DATA_W-1:0]        out_row [DIM];
  logic [IDX_W-1:0]         out_col;
  logic                     out_valid;

  assign en          = !out_valid || m_tready;
  assign fire        = cmd.issue && en;
  assign sts.advance = en;

  // Operand storage: loads shift columns in, issues rotate in place.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < DIM - 1; k++) begin
        left_m[k]  <= left_m[k + 1];
        right_m[k] <= right_m[k + 1];
      end
      for (int r = 0; r < DIM; r++) begin
        left_m[DIM-1][r]  <= s_tdata[r * DATA_W +: DATA_W];
        right_m[DIM-1][r] <= s_tdata[(DIM + r) * DATA_W +: DATA_W];
      end
    end else if (fire) begin
      for (int k = 0; k < DIM; k++) begin
        for (int i = 0; i < DIM; i++) begin
          left_m[k][i] <= left_m[k][(i + 1) % DIM];
        end
      end
      if (cmd.row == IDX_W'(DIM - 1)) begin
        for (int k = 0; k < DIM; k++) begin
          right_m[k] <= right_m[(k + 1) % DIM];
        end
      end
    end
  end

  // Three-stage element pipeline: products, pair sums, full sum.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIM; k++) begin
        prod[k] <= left_m[k][0] * right_m[0][k];
      end
      row1  <= cmd.row;
      col1  <= cmd.col;
      sum01 <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      sum23 <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
      row2  <= row1;
      col2  <= col1;
      total <= SUM_W'(sum01) + SUM_W'(sum23);
      row3  <= row2;
      col3  <= col2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= fire;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Scale back to Q16.16 and clamp to the 32-bit range.
  assign shifted = total >>> FRAC_BITS;

  always_comb begin
    if ((&shifted[SUM_W-1:DATA_W-1]) || !(|shifted[SUM_W-1:DATA_W-1])) begin
      sat = shifted[DATA_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // Rows 0..2 wait in the collector; row 3 completes the output column.
  always_ff @(posedge clk) begin
    if (en && v3) begin
      if (row3 == IDX_W'(DIM - 1)) begin
        for (int r = 0; r < DIM - 1; r++) begin
          out_row[r] <= coll[r];
        end
        out_row[DIM-1] <= sat;
        out_col        <= col3;
      end else begin
        coll[row3] <= sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && v3 && row3 == IDX_W'(DIM - 1)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      m_tdata[r * DATA_W +: DATA_W] = out_row[r];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_col;
  assign m_tlast  = (out_col == IDX_W'(DIM - 1));

`ifndef NO_ASSERTIONS
  a_col_done: assert property (@(posedge clk) disable iff (rst)
    (en && v3 && row3 == IDX_W'(DIM - 1)) |=> (out_valid && out_col == $past(col3)))
    else $error("completed column did not reach the output register");
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (en && v1 && v2) |-> (row1 == row2 + IDX_W'(1)))
    else $error("elements left the pipeline out of row order");
`endif

endmodule

// ===== hw/rtl/matrix_multiply_4x4.sv =====
// 4x4 fixed-point matrix multiplier, result = left * right, all matrices
// column-major and all elements signed Q16.16. Each input item carries one
// column of the left matrix and the same-numbered column of the right
// matrix, columns 0 to 3 in order; the block counts them itself. Items are
// accepted back to back while loading. After the fourth item the block stops
// accepting input while a sequencer feeds the sixteen result elements, one
// per cycle while the output is not stalled, into a single four-multiplier
// dot-product pipeline (products, pair sums, full 66-bit sum, then arithmetic
// shift by FRAC_BITS and saturation). Each output item is one result column;
// m_tuser gives its number and m_tlast marks column 3. A stalled output
// freezes the whole element pipeline, so nothing is lost.
module matrix_multiply_4x4 #(
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input item.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // From bit 0 up: left_row0, left_row1, left_row2, left_row3,
  // right_row0, right_row1, right_row2, right_row3 (32 bits each).
  input  logic [mm4_pkg::IN_TDATA_W-1:0]   s_tdata,
  // Result item.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // From bit 0 up: result_row0, result_row1, result_row2, result_row3.
  output logic [mm4_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // column_number.
  output logic [mm4_pkg::IDX_W-1:0]        m_tuser,
  // last_column.
  output logic                             m_tlast
);
  import mm4_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The sequencer: load counting and element issue order.
  mm4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Operand registers, the dot-product pipeline and the output register.
  mm4_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
